### src/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants of the retransmission timer table.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int MAX_SLOTS   = 16;
  localparam int SLOT_W      = 4;
  localparam int ACTION_W    = 3;
  localparam int EVENT_W     = 8;
  localparam int PORT_W      = 8;
  localparam int COUNT_W     = 8;
  localparam int INTERVAL_W  = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] FOREVER_COUNT = 8'hFF;

  // request action codes as they arrive on the port
  localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REGISTER = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_START    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_STOP     = 3'd4;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRE  = 1'b1;

  // classified operation; out-of-table and unknown requests fold into OP_BAD
  typedef enum logic [2:0] {
    OP_TICK,
    OP_REG,
    OP_DEL,
    OP_START,
    OP_STOP,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [SLOT_W-1:0]     slot;
    logic [EVENT_W-1:0]    event_id;
    logic [PORT_W-1:0]     port;
    logic [COUNT_W-1:0]    repeat_count;
    logic [INTERVAL_W-1:0] interval;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLOSE
  } back_state_e;

endpackage

### src/rtt_front.sv
// ----------------------------------------------------------------------------
// rtt_front
// Accepts requests, classifies them and holds one until the queue takes it.
// ----------------------------------------------------------------------------
module rtt_front #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rtt_pkg::ACTION_W-1:0]       action_i,
  input  logic [rtt_pkg::SLOT_W-1:0]         slot_i,
  input  logic [rtt_pkg::EVENT_W-1:0]        event_id_i,
  input  logic [rtt_pkg::PORT_W-1:0]         port_i,
  input  logic [rtt_pkg::COUNT_W-1:0]        repeat_count_i,
  input  logic [rtt_pkg::INTERVAL_W-1:0]     interval_i,
  output logic                               push_o,
  output rtt_pkg::cmd_t                      cmd_o,
  input  logic                               q_full_i
);
  import rtt_pkg::*;

  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W+1)'(NUM_SLOTS);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;
  logic in_table;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !q_full_i;
  assign cmd_o      = cmd_q;
  assign in_table   = {1'b0, slot_i} < SLOT_LIMIT;

  always_comb begin
    cmd_d.slot         = slot_i;
    cmd_d.event_id     = event_id_i;
    cmd_d.port         = port_i;
    cmd_d.repeat_count = repeat_count_i;
    cmd_d.interval     = interval_i;
    unique case (action_i)
      ACT_TICK:     cmd_d.op = OP_TICK;
      ACT_REGISTER: cmd_d.op = OP_REG;
      ACT_DELETE:   cmd_d.op = in_table ? OP_DEL : OP_BAD;
      ACT_START:    cmd_d.op = in_table ? OP_START : OP_BAD;
      ACT_STOP:     cmd_d.op = in_table ? OP_STOP : OP_BAD;
      default:      cmd_d.op = OP_BAD;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

### src/rtt_queue.sv
// ----------------------------------------------------------------------------
// rtt_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module rtt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rtt_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rtt_pkg::cmd_t  cmd_o
);
  import rtt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == DEPTH_CNT;
  assign valid_o = count_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### src/rtt_back.sv
// ----------------------------------------------------------------------------
// rtt_back
// Slot table and executor: runs one command at a time, walks the slots on a
// tick and drives the result register.
// ----------------------------------------------------------------------------
module rtt_back #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  rtt_pkg::cmd_t                  q_cmd_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           kind_o,
  output logic                           ok_o,
  output logic [rtt_pkg::SLOT_W-1:0]     slot_out_o,
  output logic [rtt_pkg::EVENT_W-1:0]    event_out_o,
  output logic [rtt_pkg::PORT_W-1:0]     port_out_o,
  output logic                           last_o
);
  import rtt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // slot table
  logic [NUM_SLOTS-1:0]  reg_q;
  logic [NUM_SLOTS-1:0]  run_q;
  logic [EVENT_W-1:0]    event_q   [NUM_SLOTS];
  logic [PORT_W-1:0]     port_q    [NUM_SLOTS];
  logic [COUNT_W-1:0]    remain_q  [NUM_SLOTS];
  logic [INTERVAL_W-1:0] ivl_q     [NUM_SLOTS];
  logic [INTERVAL_W-1:0] elapsed_q [NUM_SLOTS];

  back_state_e state_q, state_d;
  logic [IDX_W-1:0] widx_q, widx_d;

  // result register
  logic               out_valid_q;
  logic               kind_q, ok_q, last_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [EVENT_W-1:0] event_q_out;
  logic [PORT_W-1:0]  port_q_out;

  logic               can_emit, emit;
  logic               res_kind, res_ok, res_last;
  logic [SLOT_W-1:0]  res_slot;
  logic [EVENT_W-1:0] res_event;
  logic [PORT_W-1:0]  res_port;

  logic             set_reg, clr_reg, set_run, clr_run;
  logic             id_we, tmr_we, ela_we, rem_we;
  logic [IDX_W-1:0] wr_idx, cidx, free_idx;
  logic             free_found;
  logic [INTERVAL_W-1:0] ela_inc, ela_wd;
  logic [COUNT_W-1:0]    rem_cur, rem_wd;
  logic             w_active, w_fire;

  assign can_emit = !out_valid_q || !out_stall_i;
  assign cidx     = q_cmd_i.slot[IDX_W-1:0];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!reg_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // per-slot tick step at the walk index
  assign rem_cur  = remain_q[widx_q];
  assign ela_inc  = elapsed_q[widx_q] + 1'b1;
  assign w_active = reg_q[widx_q] && run_q[widx_q];
  assign w_fire   = w_active && (rem_cur != '0) && (ela_inc >= ivl_q[widx_q]);

  always_comb begin
    state_d   = state_q;
    widx_d    = widx_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    res_kind  = KIND_REPLY;
    res_ok    = 1'b0;
    res_slot  = '0;
    res_event = '0;
    res_port  = '0;
    res_last  = 1'b0;
    set_reg   = 1'b0;
    clr_reg   = 1'b0;
    set_run   = 1'b0;
    clr_run   = 1'b0;
    id_we     = 1'b0;
    tmr_we    = 1'b0;
    ela_we    = 1'b0;
    ela_wd    = ela_inc;
    rem_we    = 1'b0;
    rem_wd    = rem_cur - 1'b1;
    wr_idx    = cidx;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && can_emit) begin
          pop_o    = 1'b1;
          emit     = 1'b1;
          res_last = 1'b1;
          unique case (q_cmd_i.op)
            OP_TICK: begin
              emit    = 1'b0;
              widx_d  = '0;
              state_d = ST_WALK;
            end
            OP_REG: begin
              wr_idx = free_idx;
              if (free_found) begin
                set_reg  = 1'b1;
                id_we    = 1'b1;
                res_ok   = 1'b1;
                res_slot = SLOT_W'(free_idx);
              end
            end
            OP_DEL: begin
              if (reg_q[cidx]) begin
                clr_reg = 1'b1;
                clr_run = 1'b1;
                res_ok  = 1'b1;
              end
            end
            OP_START: begin
              if (reg_q[cidx] && !run_q[cidx]) begin
                set_run = 1'b1;
                tmr_we  = 1'b1;
                res_ok  = 1'b1;
              end
            end
            OP_STOP: begin
              if (reg_q[cidx] && run_q[cidx]) begin
                clr_run = 1'b1;
                res_ok  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        wr_idx = widx_q;
        if (can_emit) begin
          if (w_active) begin
            if (rem_cur != '0) begin
              ela_we = 1'b1;
              if (w_fire) begin
                ela_wd    = '0;
                rem_we    = rem_cur != FOREVER_COUNT;
                emit      = 1'b1;
                res_kind  = KIND_FIRE;
                res_ok    = 1'b1;
                res_slot  = SLOT_W'(widx_q);
                res_event = event_q[widx_q];
                res_port  = port_q[widx_q];
              end
            end else begin
              // count ran out: the slot stops
              clr_run = 1'b1;
            end
          end
          if (widx_q == LAST_IDX) begin
            state_d = ST_CLOSE;
          end else begin
            widx_d = widx_q + 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        if (can_emit) begin
          emit     = 1'b1;
          res_ok   = 1'b1;
          res_last = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      widx_q      <= '0;
      reg_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      widx_q  <= widx_d;
      if (set_reg) begin
        reg_q[wr_idx] <= 1'b1;
      end else if (clr_reg) begin
        reg_q[wr_idx] <= 1'b0;
      end
      if (set_run) begin
        run_q[wr_idx] <= 1'b1;
      end else if (clr_run) begin
        run_q[wr_idx] <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      event_q[wr_idx] <= q_cmd_i.event_id;
      port_q[wr_idx]  <= q_cmd_i.port;
    end
    if (tmr_we) begin
      remain_q[wr_idx]  <= q_cmd_i.repeat_count;
      ivl_q[wr_idx]     <= q_cmd_i.interval;
      elapsed_q[wr_idx] <= '0;
    end
    if (ela_we) begin
      elapsed_q[wr_idx] <= ela_wd;
    end
    if (rem_we) begin
      remain_q[wr_idx] <= rem_wd;
    end
    if (emit) begin
      kind_q      <= res_kind;
      ok_q        <= res_ok;
      slot_q      <= res_slot;
      event_q_out <= res_event;
      port_q_out  <= res_port;
      last_q      <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign ok_o        = ok_q;
  assign slot_out_o  = slot_q;
  assign event_out_o = event_q_out;
  assign port_out_o  = port_q_out;
  assign last_o      = last_q;

  a_run_needs_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q & ~reg_q) == '0)
    else $error("running slot that is not registered");

  a_fire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_FIRE) |-> !last_q && ok_q)
    else $error("fire result marked last or failed");

  a_single_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && pop_o && (q_cmd_i.op != OP_TICK) |=> out_valid_q && last_q)
    else $error("non-tick request gave no closing reply");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (widx_q <= LAST_IDX))
    else $error("walk index past the table");

  a_tick_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLOSE) && can_emit |=> out_valid_q && last_q && ok_q
      && (kind_q == KIND_REPLY) && (state_q == ST_IDLE))
    else $error("tick walk did not close with a reply");

endmodule

### src/retransmit_timer_table.sv
// ----------------------------------------------------------------------------
// retransmit_timer_table
// Table of retransmission slots with register, delete, start, stop and tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o  | action, slot, event_id, port,
//          |           |                      | repeat_count, interval
//  out     | output    | out_valid_o/out_stall_i| kind, ok, slot_out, event_out,
//          |           |                      | port_out, last
//
//  Register, delete, start and stop are carried out in the back end's idle
//  state when the queue is popped; a tick is the dispatch step, a walk of one
//  slot per cycle (while the output is not stalled) through the slot table's
//  single read/write index, then the closing reply. A non-tick reply passes
//  the front register and the queue entry, and the queue pop loads the result
//  register. Reset clears all slots and empties the queue.
//  A stalled output freezes the back end; the front keeps taking requests
//  until the queue and front register are full.
// ----------------------------------------------------------------------------
module retransmit_timer_table #(
  parameter int SLOTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rtt_pkg::ACTION_W-1:0]       action_i,
  input  logic [rtt_pkg::SLOT_W-1:0]         slot_i,
  input  logic [rtt_pkg::EVENT_W-1:0]        event_id_i,
  input  logic [rtt_pkg::PORT_W-1:0]         port_i,
  input  logic [rtt_pkg::COUNT_W-1:0]        repeat_count_i,
  input  logic [rtt_pkg::INTERVAL_W-1:0]     interval_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               kind_o,
  output logic                               ok_o,
  output logic [rtt_pkg::SLOT_W-1:0]         slot_out_o,
  output logic [rtt_pkg::EVENT_W-1:0]        event_out_o,
  output logic [rtt_pkg::PORT_W-1:0]         port_out_o,
  output logic                               last_o
);
  import rtt_pkg::*;

  // the slot field addresses at most MAX_SLOTS entries
  localparam int USED_SLOTS = (SLOTS > MAX_SLOTS) ? MAX_SLOTS : SLOTS;

  logic push, q_full, q_valid, pop;
  cmd_t front_cmd, q_cmd;

  rtt_front #(
    .NUM_SLOTS(USED_SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .slot_i        (slot_i),
    .event_id_i    (event_id_i),
    .port_i        (port_i),
    .repeat_count_i(repeat_count_i),
    .interval_i    (interval_i),
    .push_o        (push),
    .cmd_o         (front_cmd),
    .q_full_i      (q_full)
  );

  rtt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .cmd_o  (q_cmd)
  );

  rtt_back #(
    .NUM_SLOTS(USED_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .ok_o       (ok_o),
    .slot_out_o (slot_out_o),
    .event_out_o(event_out_o),
    .port_out_o (port_out_o),
    .last_o     (last_o)
  );

endmodule
